// ===== rtl/five_point_smoothing_stencil_unit_macros.svh =====
`ifndef FIVE_POINT_SMOOTHING_STENCIL_UNIT_MACROS_SVH
`define FIVE_POINT_SMOOTHING_STENCIL_UNIT_MACROS_SVH

// concurrent check, switched off while reset is high
`define FPSS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define FPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fpss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpss_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int ROWS_W    = 13;
  localparam int COLS_W    = 9;
  localparam int ROW_CNT_W = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // defaults and limits
  localparam int MAX_COLS_DEF = 256;
  localparam int MIN_DIM      = 2;
  localparam int ROW_LIMIT    = 4096;
  localparam int ROWS_RESET   = 256;
  localparam int COLS_RESET   = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef enum logic [0:0] {
    FUNC_SAMPLE = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [SAMPLE_W-1:0] sample;
  } fpss_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                end_of_frame;
  } fpss_out_t;

  // line store access control
  typedef struct packed {
    logic rd;
    logic wr;
  } fpss_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fpss_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpss_line_store #(
  parameter int MAX_COLS = fpss_pkg::MAX_COLS_DEF,
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire                            clk,
  input  fpss_pkg::fpss_mem_ctl_t        ctl,
  input  wire  [AW-1:0]                  col,
  input  wire  [AW-1:0]                  next_col,
  input  wire  [fpss_pkg::SAMPLE_W-1:0]  wr_upper,
  input  wire  [fpss_pkg::SAMPLE_W-1:0]  wr_middle,
  output logic [fpss_pkg::SAMPLE_W-1:0]  up_q,
  output logic [fpss_pkg::SAMPLE_W-1:0]  mid_q
);

  logic [fpss_pkg::SAMPLE_W-1:0] upper_mem  [MAX_COLS];
  logic [fpss_pkg::SAMPLE_W-1:0] middle_mem [MAX_COLS];

  // row shift: centre row moves up, new sample lands in the centre row
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      upper_mem[col]  <= wr_upper;
      middle_mem[col] <= wr_middle;
    end
  end

  // north of this column, and centre row one column ahead (east / next centre)
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      up_q  <= upper_mem[col];
      mid_q <= middle_mem[next_col];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/five_point_smoothing_stencil_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Five-point smoothing of a height map streamed in raster order.
// Source channel (src_valid / src_stall / src_item): one item per cycle, func
// selects a new sample or a drain step. Result channel (res_valid / res_stall
// / res_item): smoothed height, end_of_frame set on the last grid point.
// Samples of row 0 give no result; each later sample gives the result for
// the point above it. After the last sample, one drain item per point of the
// last row pushes it out; drain items at other times, and samples while
// draining, are taken and ignored. An accepted item passes the compute stage,
// then the output register. Throughput: one item per cycle while src_stall is
// low; each sample reads both line stores once and writes once, a drain step
// only reads, and the next centre value is fetched as this east. A stalled
// result is held in the output register; one more item can enter the compute
// stage behind it, then src_stall rises until the result goes. Reset (rst,
// synchronous) empties the pipeline and returns to row 0, column 0 with 256
// rows and 256 columns; src_stall is high during reset. The user must write
// registers via cfg_wr_en / cfg_index / cfg_data only while idle, which the
// block does not check. Writes return to row 0, column 0; stores not cleared.
module five_point_smoothing_stencil_unit #(
  parameter int MAX_COLS = fpss_pkg::MAX_COLS_DEF,
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              src_valid,
  output logic                             src_stall,
  input  fpss_pkg::fpss_in_t               src_item,
  output logic                             res_valid,
  input  wire                              res_stall,
  output fpss_pkg::fpss_out_t              res_item,
  input  wire                              cfg_wr_en,
  input  wire  [fpss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [fpss_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW = ($clog2(MAX_COLS + 1) > fpss_pkg::COLS_W) ?
                      $clog2(MAX_COLS + 1) : fpss_pkg::COLS_W;
  localparam int SW = fpss_pkg::SAMPLE_W;
  localparam int AccW = SW + 3;

  logic [fpss_pkg::ROWS_W-1:0]    num_rows;
  logic [fpss_pkg::COLS_W-1:0]    num_cols;
  logic [AW-1:0]                  col;
  logic [fpss_pkg::ROW_CNT_W-1:0] row;
  logic                           draining;
  logic [SW-1:0]                  west;

  logic [CW-1:0]                  eff_cols;
  logic [fpss_pkg::ROWS_W-1:0]    eff_rows;
  logic                           src_acc;
  logic                           is_drain;
  logic                           active;
  logic                           produce;
  logic                           last_col;
  logic                           last_row;
  logic [AW-1:0]                  next_col;

  fpss_pkg::fpss_mem_ctl_t        mem_ctl;
  logic [SW-1:0]                  up_q;
  logic [SW-1:0]                  mid_q;

  logic                           s1_valid;
  logic                           s1_adv;
  logic [SW-1:0]                  s1_centre;
  logic [SW-1:0]                  s1_west;
  logic [SW-1:0]                  s1_south;
  logic                           s1_north_en;
  logic                           s1_east_en;
  logic                           s1_eof;
  logic [AccW-1:0]                acc;

  // clamp frame dimensions
  always_comb begin
    eff_cols = CW'(num_cols);
    if (eff_cols < CW'(fpss_pkg::MIN_DIM)) eff_cols = CW'(fpss_pkg::MIN_DIM);
    if (eff_cols > CW'(MAX_COLS)) eff_cols = CW'(MAX_COLS);
    eff_rows = num_rows;
    if (eff_rows < fpss_pkg::ROWS_W'(fpss_pkg::MIN_DIM)) begin
      eff_rows = fpss_pkg::ROWS_W'(fpss_pkg::MIN_DIM);
    end
    if (eff_rows > fpss_pkg::ROWS_W'(fpss_pkg::ROW_LIMIT)) begin
      eff_rows = fpss_pkg::ROWS_W'(fpss_pkg::ROW_LIMIT);
    end
  end

  // scan position
  assign last_col = (CW'(col) + CW'(1)) == eff_cols;
  assign last_row = (fpss_pkg::ROWS_W'(row) + fpss_pkg::ROWS_W'(1)) >= eff_rows;
  assign next_col = last_col ? '0 : col + AW'(1);

  // item classification
  assign s1_adv    = !res_valid || !res_stall;
  assign src_stall = rst || (s1_valid && !s1_adv);
  assign src_acc   = src_valid && !src_stall;
  assign is_drain  = src_item.func == fpss_pkg::FUNC_DRAIN;
  assign active    = src_acc && (is_drain ? draining : !draining);
  assign produce   = active && (is_drain || (row != '0));

  // line store access
  assign mem_ctl.rd = active;
  assign mem_ctl.wr = active && !is_drain;

  fpss_line_store #(
    .MAX_COLS (MAX_COLS)
  ) u_line_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .col       (col),
    .next_col  (next_col),
    .wr_upper  (mid_q),
    .wr_middle (src_item.sample),
    .up_q      (up_q),
    .mid_q     (mid_q)
  );

  // configuration and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= fpss_pkg::ROWS_W'(fpss_pkg::ROWS_RESET);
      num_cols <= fpss_pkg::COLS_W'(fpss_pkg::COLS_RESET);
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
      west     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fpss_pkg::REG_NUM_ROWS: num_rows <= cfg_data;
        fpss_pkg::REG_NUM_COLS: num_cols <= cfg_data[fpss_pkg::COLS_W-1:0];
        default: ;
      endcase
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
    end else if (active) begin
      west <= mid_q;
      col  <= next_col;
      if (last_col) begin
        if (is_drain) begin
          draining <= 1'b0;
          row      <= '0;
        end else if (last_row) begin
          draining <= 1'b1;
          row      <= '0;
        end else begin
          row <= row + fpss_pkg::ROW_CNT_W'(1);
        end
      end
    end
  end

  // compute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_acc) begin
      s1_valid <= produce;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // compute stage operands, east and north arrive from the line store
  always_ff @(posedge clk) begin
    if (active) begin
      s1_centre   <= mid_q;
      s1_west     <= (col != '0) ? west : '0;
      s1_south    <= is_drain ? '0 : src_item.sample;
      s1_north_en <= is_drain || (row >= fpss_pkg::ROW_CNT_W'(2));
      s1_east_en  <= !last_col;
      s1_eof      <= is_drain && last_col;
    end
  end

  // (4*centre + north + south + west + east) >> 3
  always_comb begin
    acc = {1'b0, s1_centre, 2'b00}
        + AccW'(s1_north_en ? up_q : '0)
        + AccW'(s1_south)
        + AccW'(s1_west)
        + AccW'(s1_east_en ? mid_q : '0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res_item.smoothed     <= acc[AccW-1:3];
      res_item.end_of_frame <= s1_eof;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fpss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "five_point_smoothing_stencil_unit_macros.svh"

module fpss_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 src_valid,
  input wire                 src_stall,
  input wire                 res_valid,
  input wire                 res_stall,
  input fpss_pkg::fpss_out_t res_item
);

  // a stalled result item stays offered
  `FPSS_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid, "result dropped while stalled")

  // a stalled result item keeps its value
  `FPSS_ASSERT(a_res_stable, clk, rst, res_valid && res_stall |=> $stable(res_item), "result changed while stalled")

  // every new result goes back to an earlier accepted item
  `FPSS_ASSERT(a_res_cause, clk, rst, $rose(res_valid) |-> $past(src_valid && !src_stall, 2), "result without an accepted item")

  // reset empties the output
  `FPSS_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind five_point_smoothing_stencil_unit fpss_checker u_fpss_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

`default_nettype wire

// ===== tb/tb_five_point_smoothing_stencil_unit.sv =====
`timescale 1ns / 1ps

module tb_five_point_smoothing_stencil_unit;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int FULL_FRAME    = 100000;
  localparam int PRINT_CAP     = 200;
  localparam int SW            = fpss_pkg::SAMPLE_W;
  localparam int IW            = fpss_pkg::CFG_IDX_W;
  localparam int DW            = fpss_pkg::CFG_W;

  logic                  clk;
  logic                  rst;
  logic                  src_valid;
  logic                  src_stall;
  fpss_pkg::fpss_in_t    src_item;
  logic                  res_valid;
  logic                  res_stall;
  fpss_pkg::fpss_out_t   res_item;
  logic                  cfg_wr_en;
  logic [IW-1:0]         cfg_index;
  logic [DW-1:0]         cfg_data;

  // one row of the directed plan: a register write or an item
  typedef struct {
    bit                  is_reg;
    logic [IW-1:0]       idx;
    logic [DW-1:0]       val;
    fpss_pkg::fpss_in_t  item;
    bit                  typed;
    fpss_pkg::fpss_out_t want;
  } step_row_t;

  // mirror of the block: geometry, line stores and scan position
  logic [DW-1:0]                 rows_reg;
  logic [fpss_pkg::COLS_W-1:0]   cols_reg;
  logic [SW-1:0]                 upper_row [fpss_pkg::MAX_COLS_DEF];
  logic [SW-1:0]                 middle_row [fpss_pkg::MAX_COLS_DEF];
  logic [SW-1:0]                 west_val;
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  bit                            drain_phase;

  fpss_pkg::fpss_out_t smoothed_due [$];
  int unsigned         live_items;
  int unsigned         err_count;
  int unsigned         cycle_count;
  bit                  quiet;

  five_point_smoothing_stencil_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // weighted sum: half the centre plus an eighth of each neighbour, truncated
  function automatic logic [SW-1:0] smooth5(input logic [SW-1:0] centre,
                                            input logic [SW-1:0] north,
                                            input logic [SW-1:0] south,
                                            input logic [SW-1:0] west,
                                            input logic [SW-1:0] east);
    logic [SW+2:0] acc;
    acc = {centre, 2'b00} + north + south + west + east;
    return acc[SW+2:3];
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < fpss_pkg::MIN_DIM) return fpss_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the mirror by one item; returns 1 when the item yields a result
  function automatic bit smooth_grid_step(input fpss_pkg::fpss_in_t it,
                                          output fpss_pkg::fpss_out_t res);
    int unsigned   ncols;
    int unsigned   nrows;
    int unsigned   c;
    logic [SW-1:0] centre;
    logic [SW-1:0] north;
    logic [SW-1:0] west;
    logic [SW-1:0] east;
    bit            made;
    ncols  = clamp_dim(cols_reg, fpss_pkg::MAX_COLS_DEF);
    nrows  = clamp_dim(rows_reg, fpss_pkg::ROW_LIMIT);
    c      = (col_pos >= ncols) ? 0 : col_pos;
    made   = 1'b0;
    res    = '0;
    centre = middle_row[c];
    west   = (c > 0) ? west_val : '0;
    east   = (c + 1 < ncols) ? middle_row[c + 1] : '0;
    if (it.func == fpss_pkg::FUNC_SAMPLE) begin
      // samples are dropped while the last row drains
      if (drain_phase) return 1'b0;
      north = (row_pos >= 2) ? upper_row[c] : '0;
      if (row_pos >= 1) begin
        res.smoothed = smooth5(centre, north, it.sample, west, east);
        made = 1'b1;
      end
      upper_row[c]  = centre;
      middle_row[c] = it.sample;
      west_val      = centre;
      c++;
      if (c >= ncols) begin
        c = 0;
        row_pos++;
        if (row_pos >= nrows) begin
          row_pos     = 0;
          drain_phase = 1'b1;
        end
      end
    end else begin
      // drain steps do nothing outside the drain phase
      if (!drain_phase) return 1'b0;
      res.smoothed = smooth5(centre, upper_row[c], '0, west, east);
      made     = 1'b1;
      west_val = centre;
      c++;
      if (c >= ncols) begin
        c                = 0;
        drain_phase      = 1'b0;
        row_pos          = 0;
        res.end_of_frame = 1'b1;
      end
    end
    col_pos = c;
    live_items++;
    return made;
  endfunction

  function automatic step_row_t reg_row(input logic [IW-1:0] idx,
                                        input logic [DW-1:0] val);
    step_row_t r;
    r        = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic step_row_t item_row(input fpss_pkg::func_t f, input logic [SW-1:0] s);
    step_row_t r;
    r             = '{default: '0};
    r.item.func   = f;
    r.item.sample = s;
    return r;
  endfunction

  function automatic step_row_t typed_row(input fpss_pkg::func_t f, input logic [SW-1:0] s,
                                          input logic [SW-1:0] v, input bit eof);
    step_row_t r;
    r                   = item_row(f, s);
    r.typed             = 1'b1;
    r.want.smoothed     = v;
    r.want.end_of_frame = eof;
    return r;
  endfunction

  // heights biased towards the extremes
  function automatic logic [SW-1:0] rand_height();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  // present one item, hold it until taken, then update the mirror
  task automatic send_item(input fpss_pkg::fpss_in_t it, input bit typed,
                           input fpss_pkg::fpss_out_t typed_res);
    fpss_pkg::fpss_out_t predicted;
    quiet = (live_items >= 300 && live_items < 600);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    if (smooth_grid_step(it, predicted))
      smoothed_due.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    src_valid <= 1'b0;
    while (smoothed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == fpss_pkg::REG_NUM_ROWS) rows_reg = val;
    else cols_reg = val[fpss_pkg::COLS_W-1:0];
    col_pos     = 0;
    row_pos     = 0;
    drain_phase = 1'b0;
  endtask

  // stream samples then drains, with stray items mixed in, up to a cap
  task automatic stream_frame(input int unsigned max_items);
    int unsigned         sent;
    fpss_pkg::fpss_in_t  it;
    fpss_pkg::fpss_out_t none;
    sent = 0;
    none = '0;
    while (!drain_phase && sent < max_items) begin
      if ($urandom_range(0, 24) == 0) begin
        it.func   = fpss_pkg::FUNC_DRAIN;
        it.sample = SW'($urandom);
        send_item(it, 1'b0, none);
      end
      it.func   = fpss_pkg::FUNC_SAMPLE;
      it.sample = rand_height();
      send_item(it, 1'b0, none);
      sent++;
    end
    while (drain_phase && sent < max_items) begin
      if ($urandom_range(0, 24) == 0) begin
        it.func   = fpss_pkg::FUNC_SAMPLE;
        it.sample = rand_height();
        send_item(it, 1'b0, none);
      end
      it.func   = fpss_pkg::FUNC_DRAIN;
      it.sample = SW'($urandom);
      send_item(it, 1'b0, none);
      sent++;
    end
    if (!drain_phase && $urandom_range(0, 3) == 0) begin
      it.func   = fpss_pkg::FUNC_DRAIN;
      it.sample = SW'($urandom);
      send_item(it, 1'b0, none);
    end
  endtask

  // random back-pressure on the result side
  always @(negedge clk) begin
    res_stall <= (!quiet && $urandom_range(0, 99) < 20);
  end

  // compare each result taken with the oldest one due
  always @(posedge clk) begin
    fpss_pkg::fpss_out_t due;
    if (!rst && res_valid && !res_stall) begin
      if (smoothed_due.size() == 0) begin
        if (err_count < PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual smoothed %0d eof %0b",
                   $time, res_item.smoothed, res_item.end_of_frame);
        err_count++;
      end else begin
        due = smoothed_due.pop_front();
        if (res_item.smoothed !== due.smoothed) begin
          if (err_count < PRINT_CAP)
            $display("%0t: smoothed mismatch, expected %0d actual %0d",
                     $time, due.smoothed, res_item.smoothed);
          err_count++;
        end
        if (res_item.end_of_frame !== due.end_of_frame) begin
          if (err_count < PRINT_CAP)
            $display("%0t: end_of_frame mismatch, expected %0b actual %0b",
                     $time, due.end_of_frame, res_item.end_of_frame);
          err_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_five_point_smoothing_stencil_unit: done, errors");
    $finish;
  end

  initial begin
    step_row_t   plan [$];
    int          i;
    int unsigned kind;
    int unsigned rows_v;
    int unsigned cols_v;
    bit          big;

    rst       = 1'b1;
    src_valid = 1'b0;
    src_item  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    err_count  = 0;
    live_items = 0;

    rows_reg    = DW'(fpss_pkg::ROWS_RESET);
    cols_reg    = fpss_pkg::COLS_W'(fpss_pkg::COLS_RESET);
    west_val    = '0;
    col_pos     = 0;
    row_pos     = 0;
    drain_phase = 1'b0;
    for (i = 0; i < fpss_pkg::MAX_COLS_DEF; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end

    // directed: 2x2 frames at the extremes, stray items, then a 2x3 frame
    plan = '{
      reg_row(fpss_pkg::REG_NUM_ROWS, 13'd0),
      reg_row(fpss_pkg::REG_NUM_COLS, 13'd1),
      item_row(fpss_pkg::FUNC_DRAIN, 16'hFFFF),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFF),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFF),
      typed_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFF, 16'd49151, 1'b0),
      typed_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFF, 16'd49151, 1'b0),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h1234),
      typed_row(fpss_pkg::FUNC_DRAIN, 16'h0000, 16'd49151, 1'b0),
      typed_row(fpss_pkg::FUNC_DRAIN, 16'h0000, 16'd49151, 1'b1),
      item_row(fpss_pkg::FUNC_DRAIN, 16'h0000),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h0000),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h0000),
      typed_row(fpss_pkg::FUNC_SAMPLE, 16'h0000, 16'd0, 1'b0),
      typed_row(fpss_pkg::FUNC_SAMPLE, 16'h0000, 16'd0, 1'b0),
      typed_row(fpss_pkg::FUNC_DRAIN, 16'hFFFF, 16'd0, 1'b0),
      typed_row(fpss_pkg::FUNC_DRAIN, 16'hFFFF, 16'd0, 1'b1),
      reg_row(fpss_pkg::REG_NUM_COLS, 13'd3),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFF),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h0000),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h8000),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h7FFF),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'h0001),
      item_row(fpss_pkg::FUNC_SAMPLE, 16'hFFFE),
      item_row(fpss_pkg::FUNC_DRAIN, 16'h5555),
      item_row(fpss_pkg::FUNC_DRAIN, 16'hAAAA),
      item_row(fpss_pkg::FUNC_DRAIN, 16'h0000)
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].val);
      else send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // full-width frame, then an oversized geometry cut short past the first row
    write_reg(fpss_pkg::REG_NUM_ROWS, 13'd2);
    write_reg(fpss_pkg::REG_NUM_COLS, 13'd256);
    stream_frame(FULL_FRAME);
    write_reg(fpss_pkg::REG_NUM_ROWS, 13'h1FFF);
    write_reg(fpss_pkg::REG_NUM_COLS, 13'h1FFF);
    stream_frame($urandom_range(260, 320));
    big = 1'b1;

    // random frames: mostly small and complete, some cut short or tall
    while (live_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        rows_v = $urandom_range(fpss_pkg::ROW_LIMIT, 8191);
        cols_v = $urandom_range(2, 16);
        write_reg(fpss_pkg::REG_NUM_ROWS, DW'(rows_v));
        write_reg(fpss_pkg::REG_NUM_COLS, DW'(cols_v));
        stream_frame($urandom_range(20, 120));
        big = 1'b1;
      end else if (kind == 8 && !big) begin
        stream_frame(FULL_FRAME);
      end else begin
        rows_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
        cols_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        // junk above the column field must be dropped
        cols_v = cols_v | ($urandom_range(0, 15) << fpss_pkg::COLS_W);
        if ($urandom_range(0, 1)) begin
          write_reg(fpss_pkg::REG_NUM_ROWS, DW'(rows_v));
          write_reg(fpss_pkg::REG_NUM_COLS, DW'(cols_v));
        end else begin
          write_reg(fpss_pkg::REG_NUM_COLS, DW'(cols_v));
          write_reg(fpss_pkg::REG_NUM_ROWS, DW'(rows_v));
        end
        stream_frame((kind == 7) ? $urandom_range(1, 30) : FULL_FRAME);
        big = 1'b0;
      end
    end

    src_valid <= 1'b0;
    while (smoothed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0)
      $display("tb_five_point_smoothing_stencil_unit: done, clean");
    else
      $display("tb_five_point_smoothing_stencil_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fpss_pkg.sv
rtl/fpss_line_store.sv
rtl/five_point_smoothing_stencil_unit.sv
rtl/fpss_checker.sv
tb/tb_five_point_smoothing_stencil_unit.sv
